>>> rtl/gas_level_percent_alarm_macros.svh
// Assertion macros of the gas level alarm checker.
`ifndef GAS_LEVEL_PERCENT_ALARM_MACROS_SVH
`define GAS_LEVEL_PERCENT_ALARM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GLPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GLPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after reset is sampled low.
`define GLPA_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) else $error(msg);

`endif

>>> rtl/glpa_pkg.sv
// Shared constants and types of the gas level alarm.
package glpa_pkg;

    localparam int ADC_BITS_DEF = 10;
    localparam int PCT_W        = 11;
    localparam int SP_W         = 7;
    localparam int HYST         = 3;
    localparam int PCT_MAX      = 999;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISABLE  = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> rtl/glpa_ifs.sv
// Handshake channel interfaces of the gas level alarm.
interface glpa_in_if #(parameter int ADC_BITS = glpa_pkg::ADC_BITS_DEF);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] sample_code;
    modport source (output valid, output sample_code, input ready);
    modport sink (input valid, input sample_code, output ready);
endinterface

interface glpa_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [glpa_pkg::PCT_W-1:0] level_percent;
    logic                              relay_on;
    logic                              alarm_triggered;
    modport source (output valid, output level_percent, output relay_on,
                    output alarm_triggered, input ready);
    modport sink (input valid, input level_percent, input relay_on,
                  input alarm_triggered, output ready);
endinterface

interface glpa_cfg_if #(parameter int DATA_W = glpa_pkg::ADC_BITS_DEF);
    logic                              valid;
    logic                              ready;
    logic [glpa_pkg::CFG_IDX_W-1:0]    index;
    logic [DATA_W-1:0]                 data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/glpa_sdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module glpa_sdiv #(
    parameter int NUM_W = 18,
    parameter int DEN_W = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_dividend,
    input  logic [DEN_W-1:0]   i_divisor,
    output logic [NUM_W-1:0]   o_quotient,
    output glpa_pkg::t_div_stat o_stat
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    // Bring in the next dividend bit and try the subtract.
    assign w_shift = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], w_ge};
        end else if (i_start) begin
            r_rem <= '0;
            r_num <= i_dividend;
            r_den <= i_divisor;
        end
    end

    assign o_quotient  = r_num;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

>>> rtl/gas_level_percent_alarm.sv
// Top level of the gas level percent alarm with hysteresis relay.
//
// Usage:
//   i_sample carries one ADC code per transaction (valid/ready). o_result
//   returns one transaction per sample: the level in percent of the span
//   between the calibrated zero code and full scale, rounded to nearest and
//   clipped to +/-999, the relay drive after this sample, and a flag that
//   says the sample met the turn-on condition.
//   i_cfg writes zero code (index 0), setpoint (1) and alarm disable (2);
//   it is always ready and is meant to be written while no sample is in work.
// Sequence:
//   After accept, a setup state (S_PREP) starts the divider, which works out
//   the quotient bit by bit while the sequencer waits in S_RUN. On the done
//   strobe it enters S_DONE, compares and loads the result register, and
//   returns to S_IDLE; only there is the next sample taken. Threshold
//   products build under the divider.
// Reset and stall:
//   Synchronous reset clears config, state, relay and result valid, but not
//   the datapath registers. A stalled result holds; the engine finishes, waits
//   with its result until the register frees, keeps i_sample not ready meanwhile.
module gas_level_percent_alarm #(
    parameter int ADC_BITS = glpa_pkg::ADC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    glpa_in_if.sink     i_sample,
    glpa_cfg_if.sink    i_cfg,
    glpa_out_if.source  o_result
);

    localparam int A     = ADC_BITS;
    localparam int NUM_W = A + 8;   // 200*|num| + den
    localparam int DEN_W = A + 2;   // 2*den
    localparam int SP_W  = glpa_pkg::SP_W;
    localparam int PCT_W = glpa_pkg::PCT_W;
    localparam int Q_W   = PCT_W - 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // Configuration
    logic [A-1:0]    r_zero;
    logic [SP_W-1:0] r_sp;
    logic            r_dis;

    // Sequencer and per-sample working registers
    logic [1:0]             r_state;
    logic signed [A:0]      r_num;
    logic [A:0]             r_den;
    logic signed [A+7:0]    r_num100;
    logic [A+7:0]           r_mc;
    logic [SP_W-1:0]        r_spb;
    logic [SP_W-1:0]        r_lob;
    logic [A+7:0]           r_psp;
    logic [A+7:0]           r_plo;
    logic                   r_relay;

    // Result register
    logic                    r_out_valid;
    logic signed [PCT_W-1:0] r_out_pct;
    logic                    r_out_relay;
    logic                    r_out_trig;

    logic                    w_in_acc;
    logic                    w_out_free;
    logic [A:0]              w_mag_full;
    logic [A-1:0]            w_mag;
    logic [NUM_W-1:0]        w_dividend;
    logic [DEN_W-1:0]        w_divisor;
    logic signed [A+7:0]     w_num_x;
    logic signed [A+7:0]     w_num100;
    logic [SP_W-1:0]         w_lo;
    logic                    w_start;
    logic [NUM_W-1:0]        w_quot;
    glpa_pkg::t_div_stat     w_div_stat;
    logic [Q_W-1:0]          w_q_sat;
    logic signed [PCT_W-1:0] w_pct;
    logic signed [A+8:0]     w_s_num100;
    logic signed [A+8:0]     w_s_psp;
    logic signed [A+8:0]     w_s_plo;
    logic signed [A+1:0]     w_s_num;
    logic signed [A+1:0]     w_s_den;
    logic                    w_trig;
    logic                    w_off;
    logic                    n_relay;

    assign i_sample.ready = (r_state == S_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign w_in_acc       = i_sample.valid && (r_state == S_IDLE);
    assign w_out_free     = !r_out_valid || o_result.ready;

    // Configuration writes; unknown indexes drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero <= '0;
            r_sp   <= '0;
            r_dis  <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                glpa_pkg::CFG_ZERO:     r_zero <= i_cfg.data[A-1:0];
                glpa_pkg::CFG_SETPOINT: r_sp   <= i_cfg.data[SP_W-1:0];
                glpa_pkg::CFG_DISABLE:  r_dis  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Setup: magnitude, rounding dividend 200*|num| + den, divisor 2*den.
    assign w_mag_full = r_num[A] ? (~r_num + 1'b1) : r_num;
    assign w_mag      = w_mag_full[A-1:0];
    assign w_dividend = ({8'd0, w_mag} << 7) + ({8'd0, w_mag} << 6)
                      + ({8'd0, w_mag} << 3) + {7'd0, r_den};
    assign w_divisor  = {r_den, 1'b0};
    assign w_num_x    = {{7{r_num[A]}}, r_num};
    assign w_num100   = (w_num_x <<< 6) + (w_num_x <<< 5) + (w_num_x <<< 2);
    assign w_lo       = (r_sp > SP_W'(glpa_pkg::HYST)) ? r_sp - SP_W'(glpa_pkg::HYST)
                                                        : '0;
    assign w_start    = (r_state == S_PREP);

    glpa_sdiv #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_sdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quot),
        .o_stat     (w_div_stat)
    );

    // Final decision: saturate percent, exact threshold compares.
    assign w_q_sat    = (w_quot > NUM_W'(glpa_pkg::PCT_MAX)) ? Q_W'(glpa_pkg::PCT_MAX)
                                                             : w_quot[Q_W-1:0];
    assign w_pct      = r_num[A] ? -$signed({1'b0, w_q_sat}) : $signed({1'b0, w_q_sat});
    assign w_s_num100 = {r_num100[A+7], r_num100};
    assign w_s_psp    = {1'b0, r_psp};
    assign w_s_plo    = {1'b0, r_plo};
    assign w_s_num    = {r_num[A], r_num};
    assign w_s_den    = {1'b0, r_den};
    assign w_trig     = !r_dis && (w_s_num100 > w_s_psp) && (w_s_num <= w_s_den);
    assign w_off      = (w_s_num100 <= w_s_plo);

    always_comb begin
        priority if (r_dis) begin
            n_relay = 1'b0;
        end else if (w_trig) begin
            n_relay = 1'b1;
        end else if (w_off) begin
            n_relay = 1'b0;
        end else begin
            n_relay = r_relay;
        end
    end

    // Sequencer and result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_relay     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Load on a finished sample, drop once the receiver takes it.
            priority if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end else begin
                r_out_valid <= r_out_valid;
            end
            unique case (r_state)
                S_IDLE: if (w_in_acc) begin
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_state <= S_RUN;
                end
                S_RUN: if (w_div_stat.done) begin
                    r_state <= S_DONE;
                end
                S_DONE: if (w_out_free) begin
                    r_relay     <= n_relay;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_num <= $signed({1'b0, i_sample.sample_code}) - $signed({1'b0, r_zero});
            r_den <= {1'b1, {A{1'b0}}} - {1'b0, r_zero};
        end
        if (r_state == S_PREP) begin
            r_num100 <= w_num100;
            r_mc     <= {7'd0, r_den};
            r_spb    <= r_sp;
            r_lob    <= w_lo;
            r_psp    <= '0;
            r_plo    <= '0;
        end else if (r_state == S_RUN) begin
            // Shift-and-add: one setpoint bit per cycle.
            if (r_spb[0]) begin
                r_psp <= r_psp + r_mc;
            end
            if (r_lob[0]) begin
                r_plo <= r_plo + r_mc;
            end
            r_mc  <= r_mc << 1;
            r_spb <= r_spb >> 1;
            r_lob <= r_lob >> 1;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_pct   <= w_pct;
            r_out_relay <= n_relay;
            r_out_trig  <= w_trig;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.level_percent   = r_out_pct;
    assign o_result.relay_on        = r_out_relay;
    assign o_result.alarm_triggered = r_out_trig;

endmodule

>>> rtl/glpa_checker.sv
// Port-level checker for the gas level alarm, bound to the top level.
`include "gas_level_percent_alarm_macros.svh"

module glpa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [glpa_pkg::PCT_W-1:0]    i_out_pct,
    input logic                          i_out_relay,
    input logic                          i_out_trig
);

    `GLPA_ASSERT_NXT(a_stall_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_pct) && $stable(i_out_relay) && $stable(i_out_trig),
        "result changed while stalled")

    `GLPA_ASSERT_IMP(a_trig_relay, i_out_valid && i_out_trig, i_out_relay,
        "turn-on sample without relay on")

    `GLPA_ASSERT_IMP(a_relay_level, i_out_valid && i_out_relay,
        !i_out_pct[glpa_pkg::PCT_W-1], "relay on with negative level")

    `GLPA_ASSERT_RST(a_reset_clear, !i_out_valid, "result valid after reset")

endmodule

bind gas_level_percent_alarm glpa_checker u_glpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_pct   (o_result.level_percent),
    .i_out_relay (o_result.relay_on),
    .i_out_trig  (o_result.alarm_triggered)
);
